@@ rtl/core/mtcr_pkg.sv @@
// ----------------------------------------------------------------------------
// mtcr_pkg: shared types and constants for the monochrome text cell renderer
// Holds the beat payload structs, the register map and the cell work type.
// ----------------------------------------------------------------------------
package mtcr_pkg;

   // Geometry of one character cell row.
   localparam int PIXELS_PER_CELL = 9;
   localparam int PIX_CNT_W       = $clog2(PIXELS_PER_CELL);
   localparam int QUEUE_DEPTH     = 2;

   // Attribute decoding constants.
   localparam logic [4:0] UNDERLINE_ROW  = 5'd13;
   localparam logic [2:0] UNDERLINE_ATTR = 3'd1;
   localparam logic [7:0] REVERSE_MASK   = 8'h77;
   localparam logic [7:0] REVERSE_VALUE  = 8'h70;
   localparam logic [2:0] LINE_CODE_HI   = 3'b110;
   localparam logic [8:0] FULL_ROW       = 9'h1ff;

   // Reset values of the registers.
   localparam logic [15:0] BLINK_RATE_RST = 16'd16;
   localparam logic [23:0] COLOR_BG_RST   = 24'h000000;
   localparam logic [23:0] COLOR_NORM_RST = 24'h00aa00;
   localparam logic [23:0] COLOR_BRT_RST  = 24'haaffaa;

   // Register map.
   typedef enum logic [2:0] {
      CSR_DISPLAY_ENABLE    = 3'd0,
      CSR_BLINK_ATTR_ENABLE = 3'd1,
      CSR_BLINK_RATE        = 3'd2,
      CSR_COLOR_BACKGROUND  = 3'd3,
      CSR_COLOR_NORMAL      = 3'd4,
      CSR_COLOR_BRIGHT      = 3'd5
   } csr_index_type;

   // Item commands.
   typedef enum logic {
      CMD_RENDER = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_code;
      logic [7:0] attribute;
      logic [7:0] glyph_row;
      logic [4:0] scan_row;
      logic       cursor_here;
      logic [8:0] cursor_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } rsp_type;

   // One classified cell: final pixel pattern and its two colors.
   typedef struct packed {
      logic [8:0]  pattern;
      logic [23:0] fg;
      logic [23:0] bg;
   } cell_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/core/mtcr_front.sv @@
// ----------------------------------------------------------------------------
// mtcr_front: item intake and classification
// Holds the registers and blink state, handles ticks and turns each render
// beat into a pixel pattern with foreground and background colors.
// ----------------------------------------------------------------------------
module mtcr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mtcr_pkg::req_type         req_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [23:0]               csr_data,
   input  mtcr_pkg::queue_status_type q_status,
   output logic                      push,
   output mtcr_pkg::cell_type        push_cell
);
   import mtcr_pkg::*;

   logic        disp_en_ff, disp_en_in;
   logic        blink_en_ff, blink_en_in;
   logic [15:0] rate_ff, rate_in;
   logic [23:0] col_bg_ff, col_bg_in;
   logic [23:0] col_norm_ff, col_norm_in;
   logic [23:0] col_brt_ff, col_brt_in;
   logic        phase_ff, phase_in;
   logic [15:0] count_ff, count_in;

   logic        accept;
   logic        csr_write;
   logic [8:0]  pattern;
   logic [23:0] fg;
   logic [23:0] bg;
   logic        reverse;

   // Palette lookup: entry 0, entries 1 to 7, entries 8 to 15.
   function automatic logic [23:0] palette(input logic [3:0] idx,
                                           input logic [23:0] c_bg,
                                           input logic [23:0] c_norm,
                                           input logic [23:0] c_brt);
      logic [23:0] res;
      if (idx == 4'd0) begin
         res = c_bg;
      end else if (idx[3] == 1'b0) begin
         res = c_norm;
      end else begin
         res = c_brt;
      end
      return res;
   endfunction

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register writes and blink countdown.
   always_comb begin
      disp_en_in  = disp_en_ff;
      blink_en_in = blink_en_ff;
      rate_in     = rate_ff;
      col_bg_in   = col_bg_ff;
      col_norm_in = col_norm_ff;
      col_brt_in  = col_brt_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      if (accept && req_payload.cmd == CMD_TICK && count_ff != 16'd0) begin
         if (count_ff == 16'd1) begin
            phase_in = !phase_ff;
            count_in = rate_ff;
         end else begin
            count_in = count_ff - 16'd1;
         end
      end
      if (csr_write) begin
         case (csr_index)
            CSR_DISPLAY_ENABLE: begin
               disp_en_in = csr_data[0];
            end
            CSR_BLINK_ATTR_ENABLE: begin
               blink_en_in = csr_data[0];
            end
            CSR_BLINK_RATE: begin
               rate_in  = csr_data[15:0];
               phase_in = 1'b1;
               count_in = csr_data[15:0];
            end
            CSR_COLOR_BACKGROUND: begin
               col_bg_in = csr_data;
            end
            CSR_COLOR_NORMAL: begin
               col_norm_in = csr_data;
            end
            CSR_COLOR_BRIGHT: begin
               col_brt_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_en_ff  <= 1'b0;
         blink_en_ff <= 1'b0;
         rate_ff     <= BLINK_RATE_RST;
         col_bg_ff   <= COLOR_BG_RST;
         col_norm_ff <= COLOR_NORM_RST;
         col_brt_ff  <= COLOR_BRT_RST;
         phase_ff    <= 1'b1;
         count_ff    <= BLINK_RATE_RST;
      end else begin
         disp_en_ff  <= disp_en_in;
         blink_en_ff <= blink_en_in;
         rate_ff     <= rate_in;
         col_bg_ff   <= col_bg_in;
         col_norm_ff <= col_norm_in;
         col_brt_ff  <= col_brt_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
      end
   end

   // Pattern build: glyph, line-drawing column, underline, blink, cursor, display enable.
   always_comb begin
      pattern = {req_payload.glyph_row, 1'b0};
      if (req_payload.char_code[7:5] == LINE_CODE_HI) begin
         pattern[0] = req_payload.glyph_row[0];
      end
      if (req_payload.attribute[2:0] == UNDERLINE_ATTR &&
          req_payload.scan_row == UNDERLINE_ROW) begin
         pattern = FULL_ROW;
      end
      if (req_payload.attribute[7] && blink_en_ff && !phase_ff) begin
         pattern = 9'd0;
      end
      if (req_payload.cursor_here && phase_ff) begin
         pattern = pattern | req_payload.cursor_bits;
      end
      if (!disp_en_ff) begin
         pattern = 9'd0;
      end
   end

   // Color selection with reverse video and bright background.
   always_comb begin
      reverse = (req_payload.attribute & REVERSE_MASK) == REVERSE_VALUE;
      if (!disp_en_ff) begin
         fg = 24'd0;
         bg = 24'd0;
      end else if (reverse) begin
         fg = col_bg_ff;
         bg = (req_payload.attribute[7] && !blink_en_ff) ? col_brt_ff : col_norm_ff;
      end else begin
         fg = palette(req_payload.attribute[3:0], col_bg_ff, col_norm_ff, col_brt_ff);
         bg = col_bg_ff;
      end
   end

   assign push              = accept && req_payload.cmd == CMD_RENDER;
   assign push_cell.pattern = pattern;
   assign push_cell.fg      = fg;
   assign push_cell.bg      = bg;

endmodule

@@ rtl/core/mtcr_queue.sv @@
// ----------------------------------------------------------------------------
// mtcr_queue: short cell queue between front and back
// A small register FIFO that lets intake and pixel output stall separately.
// ----------------------------------------------------------------------------
module mtcr_queue #(
   parameter int Depth = mtcr_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mtcr_pkg::cell_type         push_cell,
   input  logic                       pop,
   output mtcr_pkg::cell_type         pop_cell,
   output mtcr_pkg::queue_status_type q_status
);
   import mtcr_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   cell_type          entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_status.full  = count_ff == FullCnt;
   assign q_status.empty = count_ff == '0;
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign pop_cell = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cell;
      end
   end

endmodule

@@ rtl/core/mtcr_back.sv @@
// ----------------------------------------------------------------------------
// mtcr_back: pixel serializer
// Takes one classified cell at a time and shifts out nine RGB pixel beats.
// ----------------------------------------------------------------------------
module mtcr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mtcr_pkg::queue_status_type q_status,
   input  mtcr_pkg::cell_type         pop_cell,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mtcr_pkg::rsp_type          rsp_payload
);
   import mtcr_pkg::*;

   localparam logic [PIX_CNT_W-1:0] LastPix = PIX_CNT_W'(PIXELS_PER_CELL - 1);

   logic [8:0]           pat_ff, pat_in;
   logic [23:0]          fg_ff, fg_in;
   logic [23:0]          bg_ff, bg_in;
   logic [PIX_CNT_W-1:0] pix_ff, pix_in;
   logic                 busy_ff, busy_in;
   logic                 advance;
   logic                 last;
   logic [23:0]          color;

   assign last    = pix_ff == LastPix;
   assign advance = busy_ff && !rsp_stall;
   assign pop     = (!busy_ff || (advance && last)) && !q_status.empty;

   // Shift the pattern per delivered beat, load the next cell after the last.
   always_comb begin
      pat_in  = pat_ff;
      fg_in   = fg_ff;
      bg_in   = bg_ff;
      pix_in  = pix_ff;
      busy_in = busy_ff;
      if (advance) begin
         pat_in = {pat_ff[7:0], 1'b0};
         pix_in = pix_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         pat_in  = pop_cell.pattern;
         fg_in   = pop_cell.fg;
         bg_in   = pop_cell.bg;
         pix_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pix_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pix_ff  <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      fg_ff  <= fg_in;
      bg_ff  <= bg_in;
   end

   // Current pixel beat.
   assign color                  = pat_ff[8] ? fg_ff : bg_ff;
   assign rsp_valid              = busy_ff;
   assign rsp_payload.red        = color[23:16];
   assign rsp_payload.green      = color[15:8];
   assign rsp_payload.blue       = color[7:0];
   assign rsp_payload.last_pixel = last;

endmodule

@@ rtl/core/mono_text_cell_renderer.sv @@
// Path: an accepted render beat is written into the queue, then loaded into
// the serializer registers, which show its first pixel; the serializer gives
// one pixel per cycle while rsp_stall is low. Tick beats give no pixels.
// Reset: synchronous, active high; clears queue, serializer and loads
// register and blink defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
// mono_text_cell_renderer: monochrome text-mode cell renderer
// Front classifies cells and runs the blink timer, a short queue decouples
// it from the back, which serializes nine RGB pixels per cell.
// ----------------------------------------------------------------------------
module mono_text_cell_renderer #(
   parameter int QueueDepth = mtcr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mtcr_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mtcr_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_data
);
   import mtcr_pkg::*;

   queue_status_type q_status;
   cell_type         push_cell;
   cell_type         pop_cell;
   logic             push;
   logic             pop;

   mtcr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_status    (q_status),
      .push        (push),
      .push_cell   (push_cell)
   );

   mtcr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cell (push_cell),
      .pop       (pop),
      .pop_cell  (pop_cell),
      .q_status  (q_status)
   );

   mtcr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .pop_cell    (pop_cell),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A cell in flight keeps its pixel beats coming until the ninth.
   a_cell_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_pixel |=> rsp_valid)
      else $error("pixel beats of a cell were cut short");

   // The queue is never full and empty at once.
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue status inconsistent");

   // Nothing leaves the block right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel beat right after reset");

   // A queued cell is taken as soon as the serializer goes idle.
   a_no_idle_gap: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !q_status.empty |-> pop)
      else $error("serializer idle with a queued cell");

endmodule
